// ===== sv/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PID_WIDTH = 16;

    // Widths fixed by the word layout
    localparam int PID_W  = 16;
    localparam int PRIO_W = 4;
    localparam int OCC_W  = 5;

    // Stored id width: ids are cut to the smaller of PID_WIDTH and PID_W bits when stored
    localparam int SPID_W = (PID_WIDTH < PID_W) ? PID_WIDTH : PID_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              op;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [PID_W-1:0]  out_pid;
        logic [PRIO_W-1:0] out_prio;
        logic [PID_W-1:0]  head_pid;
        logic [PRIO_W-1:0] head_prio;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic              is_full;
    } t_out_word;

    typedef struct packed {
        logic [SPID_W-1:0] pid;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic   ins;
        logic   del;
        t_entry ent;
    } t_cell_ctl;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: keeps, takes the new entry, or takes a neighbor's.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_slot     i_left,
    input  logic               i_left_ge,
    input  spq_pkg::t_slot     i_right,
    output spq_pkg::t_slot     o_cur,
    output spq_pkg::t_slot     o_nxt,
    output logic               o_ge
);
    import spq_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_slot  n_slot;

    // Sorted chain: ge holds on a prefix, so the first cell without it takes the new entry
    assign o_ge = r_valid && (r_entry.prio >= i_ctl.ent.prio);

    always_comb begin
        n_slot.valid = r_valid;
        n_slot.entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_ge) begin
                if (i_left_ge) begin
                    n_slot.valid = 1'b1;
                    n_slot.entry = i_ctl.ent;
                end else begin
                    n_slot = i_left;
                end
            end
        end else if (i_ctl.del) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
        r_entry <= n_slot.entry;
    end

    assign o_cur.valid = r_valid;
    assign o_cur.entry = r_entry;
    assign o_nxt       = n_slot;

endmodule

// ===== sv/stable_priority_queue_core.sv =====
// Stable priority queue built as a chain of sorted cells. It takes one word per cycle: an
// enqueue or a dequeue updates every cell in the cycle it is accepted, and its result word
// appears in the output register on the next cycle. The speed is set by one priority compare
// and a three-way select in each cell. The input stalls only while a result word is held
// in the output register and the output side stalls. Equal priorities keep arrival order.
module stable_priority_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_word o_out_word
);
    import spq_pkg::*;

    t_slot      w_cur [DEPTH];
    t_slot      w_nxt [DEPTH];
    logic       w_ge  [DEPTH];
    t_cell_ctl  w_ctl;
    logic       w_acc;
    logic       w_empty;
    logic       w_full;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_out_word  n_out_word;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_empty    = !w_cur[0].valid;
    assign w_full     = w_cur[DEPTH-1].valid;

    assign w_ctl.ins      = w_acc && (i_in_word.op == OP_ENQ) && !w_full;
    assign w_ctl.del      = w_acc && (i_in_word.op == OP_DEQ) && !w_empty;
    assign w_ctl.ent.pid  = i_in_word.pid[SPID_W-1:0];
    assign w_ctl.ent.prio = i_in_word.prio;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_ge;

        if (k == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_ge = 1'b1;
        end else begin : g_mid
            assign w_left    = w_cur[k-1];
            assign w_left_ge = w_ge[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_cur[k+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .o_cur     (w_cur[k]),
            .o_nxt     (w_nxt[k]),
            .o_ge      (w_ge[k])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_out_word           = '0;
        n_out_word.status    = ST_DONE;
        if (i_in_word.op == OP_ENQ) begin
            if (w_full) begin
                n_out_word.status = ST_FULL;
            end
        end else begin
            if (w_empty) begin
                n_out_word.status = ST_EMPTY;
            end else begin
                n_out_word.out_pid  = PID_W'(w_cur[0].entry.pid);
                n_out_word.out_prio = w_cur[0].entry.prio;
            end
        end
        if (w_nxt[0].valid) begin
            n_out_word.head_pid  = PID_W'(w_nxt[0].entry.pid);
            n_out_word.head_prio = w_nxt[0].entry.prio;
        end
        n_out_word.occupancy = OCC_W'(32'(n_count));
        n_out_word.is_empty  = !w_nxt[0].valid;
        n_out_word.is_full   = w_nxt[DEPTH-1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_acc) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Count tracks the chain's fill edges
    a_empty_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == w_empty)
        else $error("count and head cell disagree on empty");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) == w_full)
        else $error("count and tail cell disagree on full");

    // Cells stay packed toward the head: a valid tail cell needs a valid head cell
    a_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cur[DEPTH-1].valid |-> w_cur[0].valid)
        else $error("hole in cell chain");

    // Head priority never below the next cell's
    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cur[1].valid |-> (w_cur[0].entry.prio >= w_cur[1].entry.prio))
        else $error("chain out of priority order");

    a_no_both : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.del))
        else $error("insert and remove in the same cycle");

endmodule
